### hw/rtl/wrc_pkg.sv
// Weightless RAM classifier: shared types and constants.
// Holds mode codes, configuration register indexes and the command record
// passed from the front end to the back end. No dependencies.
`timescale 1ns / 1ps

package wrc_pkg;

  localparam logic [2:0] MODE_TRAIN        = 3'd0;
  localparam logic [2:0] MODE_TRAIN_VALUE  = 3'd1;
  localparam logic [2:0] MODE_TRAIN_FORGET = 3'd2;
  localparam logic [2:0] MODE_RESP_COUNT   = 3'd3;
  localparam logic [2:0] MODE_RESP_SUM     = 3'd4;

  localparam logic [1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [1:0] CFG_FORGET_INC  = 2'd1;
  localparam logic [1:0] CFG_FORGET_DEC  = 2'd2;
  localparam logic [1:0] CFG_CLASS_COUNT = 2'd3;

  localparam int ScoreBits = 22;
  localparam int CountBits = 24;

  typedef struct packed {
    logic [2:0]         mode;
    logic [1:0]         label;
    logic [5:0]         ram_index;
    logic [7:0]         ram_address;
    logic signed [15:0] value;
    logic               last;
    logic               ram_ok;
    logic               label_err;
  } cmd_t;

endpackage

### hw/rtl/wrc_ram.sv
// Weightless RAM classifier: generic single-write, single-read RAM.
// Registered read data. No dependencies.
`timescale 1ns / 1ps

module wrc_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/wrc_front.sv
// Weightless RAM classifier: front end.
// Accepts requests, checks label and RAM index, and queues commands
// for the back end. Depends on wrc_pkg.
`timescale 1ns / 1ps

module wrc_front #(
  parameter int RamCount   = 64,
  parameter int NumClasses = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        mode_i,
  input  logic [1:0]                        class_label_i,
  input  logic [5:0]                        ram_index_i,
  input  logic [7:0]                        ram_address_i,
  input  logic signed [15:0]                value_i,
  input  logic                              last_i,
  input  logic [$clog2(NumClasses)-1:0]     last_cls_i,
  input  logic                              clearing_i,
  output logic                              cmd_valid_o,
  output wrc_pkg::cmd_t                     cmd_o,
  input  logic                              cmd_pop_i
);
  import wrc_pkg::*;

  cmd_t       q_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_new;
  logic       push;

  always_comb begin
    cmd_new.mode        = mode_i;
    cmd_new.label       = class_label_i;
    cmd_new.ram_index   = ram_index_i;
    cmd_new.ram_address = ram_address_i;
    cmd_new.value       = value_i;
    cmd_new.last        = last_i;
    cmd_new.ram_ok      = 32'(ram_index_i) < RamCount;
    cmd_new.label_err   = (mode_i <= MODE_TRAIN_FORGET) &&
                          (32'(class_label_i) > 32'(last_cls_i));
  end

  assign in_ready_o  = (cnt_q != 2'd2) && !clearing_i;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = q_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wptr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (cmd_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule

### hw/rtl/wrc_back.sv
// Weightless RAM classifier: back end.
// Runs queued commands against the cell RAM, keeps scores and train counts,
// and drives the result register. Depends on wrc_pkg and wrc_ram.
`timescale 1ns / 1ps

module wrc_back #(
  parameter int AddrBits   = 8,
  parameter int RamCount   = 64,
  parameter int NumClasses = 4,
  parameter int CellBits   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  wrc_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  output logic                          clearing_o,
  input  logic signed [15:0]            thr_i,
  input  logic [14:0]                   inc_i,
  input  logic [14:0]                   dec_i,
  input  logic [$clog2(NumClasses)-1:0] last_cls_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    class_index_o,
  output logic signed [21:0]            score_o,
  output logic [23:0]                   train_count_o,
  output logic [1:0]                    best_class_o,
  output logic                          error_o,
  output logic                          last_result_o
);
  import wrc_pkg::*;

  localparam int CW = $clog2(NumClasses);
  localparam int RW = (RamCount > 1) ? $clog2(RamCount) : 1;
  localparam int AB = AddrBits;
  localparam int MW = CW + RW + AB;
  localparam int EW = ((CellBits > 17) ? CellBits : 17) + 1;
  localparam int AW = ((CellBits > ScoreBits) ? CellBits : ScoreBits) + 2;
  localparam logic signed [EW-1:0] CMAX = {{(EW-CellBits+1){1'b0}}, {(CellBits-1){1'b1}}};
  localparam logic signed [EW-1:0] CMIN = ~CMAX;
  localparam logic signed [AW-1:0] SMAX = {{(AW-ScoreBits+1){1'b0}}, {(ScoreBits-1){1'b1}}};
  localparam logic signed [AW-1:0] SMIN = ~SMAX;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_TWR  = 4'd2;
  localparam logic [3:0] S_FRD  = 4'd3;
  localparam logic [3:0] S_FWR  = 4'd4;
  localparam logic [3:0] S_RACC = 4'd5;
  localparam logic [3:0] S_BEST = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;
  localparam logic [3:0] S_ERR  = 4'd8;

  logic [3:0]                  state_q;
  cmd_t                        cmd_q;
  logic [CW-1:0]               cls_q, cls_nxt, best_q;
  logic signed [ScoreBits-1:0] best_val_q;
  logic [AB-1:0]               j_q;
  logic [MW-1:0]               clr_q;
  logic signed [ScoreBits-1:0] acc_q [NumClasses];
  logic [CountBits-1:0]        cnt_q [NumClasses];

  logic                        out_valid_q, err_q, last_res_q;
  logic [1:0]                  cidx_q, best_out_q;
  logic signed [ScoreBits-1:0] score_q;
  logic [CountBits-1:0]        tcnt_q;

  logic                        we;
  logic [MW-1:0]               waddr, raddr;
  logic [CellBits-1:0]         wdata, rdata;
  logic signed [CellBits-1:0]  rd_s;
  logic signed [EW-1:0]        addend, csum, csat;
  logic                        miss;
  logic signed [AW-1:0]        rd_w, thr_w, aadd, asum;
  logic signed [ScoreBits-1:0] acc_new;
  logic [RW-1:0]               ram_q_f, ram_i_f;
  logic [AB-1:0]               adr_q_f, adr_i_f;
  logic                        out_free, finish_train, out_load;

  assign cls_nxt  = cls_q + CW'(1);
  assign ram_q_f  = RW'(cmd_q.ram_index);
  assign adr_q_f  = AB'(cmd_q.ram_address);
  assign ram_i_f  = RW'(cmd_i.ram_index);
  assign adr_i_f  = AB'(cmd_i.ram_address);
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = ((state_q == S_EMIT) || (state_q == S_ERR)) && out_free;
  assign rd_s     = $signed(rdata);
  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_valid_i;
  assign clearing_o = state_q == S_CLR;

  always_comb begin
    miss = (cmd_q.mode == MODE_TRAIN_FORGET) && (j_q != adr_q_f);
    case (cmd_q.mode)
      MODE_TRAIN:       addend = EW'(1);
      MODE_TRAIN_VALUE: addend = EW'(cmd_q.value);
      default:          addend = miss ? -EW'($signed({1'b0, dec_i}))
                                      : EW'($signed({1'b0, inc_i}));
    endcase
    csum = EW'(rd_s) + addend;
    if (csum > CMAX) begin
      csat = CMAX;
    end else if (csum < CMIN) begin
      csat = CMIN;
    end else begin
      csat = csum;
    end
    if (miss && csat < 0) begin
      csat = '0;
    end
  end

  always_comb begin
    rd_w  = AW'(rd_s);
    thr_w = AW'(thr_i);
    if (cmd_q.mode == MODE_RESP_COUNT) begin
      aadd = (rd_w > thr_w) ? AW'(1) : AW'(0);
    end else begin
      aadd = rd_w;
    end
    asum = AW'(acc_q[cls_q]) + aadd;
    if (asum > SMAX) begin
      acc_new = ScoreBits'(SMAX);
    end else if (asum < SMIN) begin
      acc_new = ScoreBits'(SMIN);
    end else begin
      acc_new = ScoreBits'(asum);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = CellBits'(csat);
    raddr = '0;
    case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
      end
      S_IDLE: begin
        if (cmd_i.mode <= MODE_TRAIN_FORGET) begin
          raddr = {CW'(cmd_i.label), ram_i_f, adr_i_f};
        end else begin
          raddr = {CW'(0), ram_i_f, adr_i_f};
        end
      end
      S_TWR: begin
        we    = cmd_q.ram_ok;
        waddr = {cls_q, ram_q_f, adr_q_f};
      end
      S_FRD: raddr = {cls_q, ram_q_f, j_q};
      S_FWR: begin
        we    = 1'b1;
        waddr = {cls_q, ram_q_f, j_q};
      end
      S_RACC: raddr = {cls_nxt, ram_q_f, adr_q_f};
      default: ;
    endcase
  end

  assign finish_train = (state_q == S_TWR) || (state_q == S_FWR && (&j_q));

  wrc_ram #(
    .Width(CellBits),
    .Depth(2 ** MW)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cls_q       <= '0;
      best_q      <= '0;
      best_val_q  <= '0;
      j_q         <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      cidx_q      <= '0;
      score_q     <= '0;
      tcnt_q      <= '0;
      best_out_q  <= '0;
      err_q       <= 1'b0;
      last_res_q  <= 1'b0;
      for (int c = 0; c < NumClasses; c++) begin
        acc_q[c] <= '0;
        cnt_q[c] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      if (finish_train) begin
        if (cmd_q.last) begin
          if (cnt_q[cls_q] != {CountBits{1'b1}}) begin
            cnt_q[cls_q] <= cnt_q[cls_q] + CountBits'(1);
          end
          for (int c = 0; c < NumClasses; c++) begin
            acc_q[c] <= '0;
          end
        end
        state_q <= S_IDLE;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + MW'(1);
          if (&clr_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.mode <= MODE_TRAIN_FORGET) begin
              cls_q <= CW'(cmd_i.label);
              j_q   <= '0;
              if (cmd_i.label_err) begin
                state_q <= S_ERR;
              end else if (cmd_i.mode == MODE_TRAIN_FORGET && cmd_i.ram_ok) begin
                state_q <= S_FRD;
              end else begin
                state_q <= S_TWR;
              end
            end else if (cmd_i.mode <= MODE_RESP_SUM) begin
              cls_q <= '0;
              if (cmd_i.ram_ok) begin
                state_q <= S_RACC;
              end else if (cmd_i.last) begin
                state_q <= S_BEST;
              end
            end else if (cmd_i.last) begin
              for (int c = 0; c < NumClasses; c++) begin
                acc_q[c] <= '0;
              end
            end
          end
        end
        S_FRD: state_q <= S_FWR;
        S_FWR: begin
          if (!(&j_q)) begin
            j_q     <= j_q + AB'(1);
            state_q <= S_FRD;
          end
        end
        S_RACC: begin
          acc_q[cls_q] <= acc_new;
          if (cls_q == last_cls_i) begin
            cls_q   <= '0;
            state_q <= cmd_q.last ? S_BEST : S_IDLE;
          end else begin
            cls_q <= cls_nxt;
          end
        end
        S_BEST: begin
          if (cls_q == '0 || acc_q[cls_q] > best_val_q) begin
            best_q     <= cls_q;
            best_val_q <= acc_q[cls_q];
          end
          if (cls_q == last_cls_i) begin
            cls_q   <= '0;
            state_q <= S_EMIT;
          end else begin
            cls_q <= cls_nxt;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            cidx_q      <= 2'(cls_q);
            score_q     <= acc_q[cls_q];
            tcnt_q      <= cnt_q[cls_q];
            best_out_q  <= 2'(best_q);
            err_q       <= 1'b0;
            last_res_q  <= cls_q == last_cls_i;
            if (cls_q == last_cls_i) begin
              for (int c = 0; c < NumClasses; c++) begin
                acc_q[c] <= '0;
              end
              state_q <= S_IDLE;
            end else begin
              cls_q <= cls_nxt;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            cidx_q      <= cmd_q.label;
            score_q     <= '0;
            tcnt_q      <= '0;
            best_out_q  <= '0;
            err_q       <= 1'b1;
            last_res_q  <= 1'b1;
            if (cmd_q.last) begin
              for (int c = 0; c < NumClasses; c++) begin
                acc_q[c] <= '0;
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign class_index_o = cidx_q;
  assign score_o       = score_q;
  assign train_count_o = tcnt_q;
  assign best_class_o  = best_out_q;
  assign error_o       = err_q;
  assign last_result_o = last_res_q;

endmodule

### hw/rtl/weightless_ram_classifier.sv
// Weightless RAM classifier top level: configuration registers, front end
// and back end. Depends on wrc_pkg, wrc_front, wrc_back and wrc_ram.
`timescale 1ns / 1ps

// After reset the block clears its cell RAM, one cell per cycle, through all
// 2^(clog2(NUM_CLASSES)+clog2(RAM_COUNT)+ADDR_BITS) cells (65536 with the
// defaults) and takes no requests until done. The cell RAM (one write port,
// one read port) sets the pace: a train or train-value request updates one
// cell, a train-forget request each of the 2^ADDR_BITS cells of its RAM in
// turn, a respond request reads one cell per class in use, and one marked
// last then scans those classes for the winner and sends one result each.
// A two-entry queue lets requests arrive while earlier ones are worked off.
module weightless_ram_classifier #(
  parameter int ADDR_BITS   = 8,
  parameter int RAM_COUNT   = 64,
  parameter int NUM_CLASSES = 4,
  parameter int CELL_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic [1:0]         class_label_i,
  input  logic [5:0]         ram_index_i,
  input  logic [7:0]         ram_address_i,
  input  logic signed [15:0] value_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         class_index_o,
  output logic signed [21:0] score_o,
  output logic [23:0]        train_count_o,
  output logic [1:0]         best_class_o,
  output logic               error_o,
  output logic               last_result_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import wrc_pkg::*;

  localparam int CW = $clog2(NUM_CLASSES);

  logic signed [15:0] thr_q;
  logic [14:0]        inc_q, dec_q;
  logic [2:0]         ccount_q;
  logic [CW-1:0]      last_cls;
  logic               cmd_valid, cmd_pop, clearing;
  cmd_t               cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= '0;
      inc_q    <= 15'd1;
      dec_q    <= 15'd1;
      ccount_q <= 3'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD:   thr_q    <= cfg_wdata_i;
        CFG_FORGET_INC:  inc_q    <= cfg_wdata_i[14:0];
        CFG_FORGET_DEC:  dec_q    <= cfg_wdata_i[14:0];
        CFG_CLASS_COUNT: ccount_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ccount_q == 3'd0) begin
      last_cls = '0;
    end else if (32'(ccount_q) > NUM_CLASSES) begin
      last_cls = CW'(NUM_CLASSES - 1);
    end else begin
      last_cls = CW'(ccount_q - 3'd1);
    end
  end

  wrc_front #(
    .RamCount  (RAM_COUNT),
    .NumClasses(NUM_CLASSES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .class_label_i(class_label_i),
    .ram_index_i  (ram_index_i),
    .ram_address_i(ram_address_i),
    .value_i      (value_i),
    .last_i       (last_i),
    .last_cls_i   (last_cls),
    .clearing_i   (clearing),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  wrc_back #(
    .AddrBits  (ADDR_BITS),
    .RamCount  (RAM_COUNT),
    .NumClasses(NUM_CLASSES),
    .CellBits  (CELL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .clearing_o   (clearing),
    .thr_i        (thr_q),
    .inc_i        (inc_q),
    .dec_i        (dec_q),
    .last_cls_i   (last_cls),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .class_index_o(class_index_o),
    .score_o      (score_o),
    .train_count_o(train_count_o),
    .best_class_o (best_class_o),
    .error_o      (error_o),
    .last_result_o(last_result_o)
  );

endmodule

### bench/weightless_ram_classifier_test.sv
// Self-checking testbench for weightless_ram_classifier: directed table, then random samples.
// Results are checked against a behavioral model of the cell RAMs held here.
// Depends on wrc_pkg and the weightless_ram_classifier RTL.
`timescale 1ns / 1ps

module weightless_ram_classifier_test;
  import wrc_pkg::*;

  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam int CellDepth  = 4 * 64 * 256;
  localparam int SettleWait = 2000;
  localparam int CycleLimit = 3000000;
  localparam int PhaseCount = 8;
  localparam int PhaseItems = 36;

  typedef struct packed {
    logic [2:0]         mode;
    logic [1:0]         label;
    logic [5:0]         ram;
    logic [7:0]         addr;
    logic signed [15:0] value;
    logic               last;
  } request_t;

  typedef struct packed {
    logic [1:0]         cls;
    logic signed [21:0] score;
    logic [23:0]        count;
    logic [1:0]         best;
    logic               err;
    logic               lastr;
  } score_t;

  typedef struct {
    request_t req;
    bit       typed;
    score_t   want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         mode_i = '0;
  logic [1:0]         class_label_i = '0;
  logic [5:0]         ram_index_i = '0;
  logic [7:0]         ram_address_i = '0;
  logic signed [15:0] value_i = '0;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         class_index_o;
  logic signed [21:0] score_o;
  logic [23:0]        train_count_o;
  logic [1:0]         best_class_o;
  logic               error_o;
  logic               last_result_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [15:0]        cfg_wdata_i = '0;

  weightless_ram_classifier dut (.*);

  always #4 clk_i = ~clk_i;

  // Model state
  logic signed [15:0] cell_mem [CellDepth];
  longint             class_acc [4];
  int unsigned        class_trained [4];
  logic signed [15:0] bleach_level;
  logic [14:0]        inc_amount;
  logic [14:0]        dec_amount;
  logic [2:0]         classes_cfg;

  score_t     pending_scores[$];
  row_t       dir_rows[$];
  request_t   sample_q[$];
  int         mismatches = 0;
  int unsigned cycles = 0;
  bit         quiet = 0;
  int         stall_left = 0;

  function automatic int unsigned active_classes();
    if (classes_cfg == 0) return 1;
    if (classes_cfg > 4) return 4;
    return classes_cfg;
  endfunction

  function automatic logic signed [15:0] clamp_cell(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic longint clamp_score(longint v);
    if (v > 2097151) return 2097151;
    if (v < -2097152) return -2097152;
    return v;
  endfunction

  function automatic void classify_step(input request_t r, ref score_t outq[$]);
    int unsigned n;
    int          base;
    longint      v;
    int unsigned best;
    score_t      s;
    n = active_classes();
    if (r.mode <= MODE_TRAIN_FORGET) begin
      if (r.label >= n) begin
        s = '{cls: r.label, score: '0, count: '0, best: '0, err: 1'b1, lastr: 1'b1};
        outq.push_back(s);
      end else begin
        base = (int'(r.label) * 64 + int'(r.ram)) * 256;
        if (r.mode == MODE_TRAIN) begin
          cell_mem[base + r.addr] = clamp_cell(longint'(cell_mem[base + r.addr]) + 1);
        end else if (r.mode == MODE_TRAIN_VALUE) begin
          cell_mem[base + r.addr] = clamp_cell(longint'(cell_mem[base + r.addr]) + r.value);
        end else begin
          for (int j = 0; j < 256; j++) begin
            v = cell_mem[base + j];
            if (j == r.addr) v += inc_amount;
            else begin
              v -= dec_amount;
              if (v < 0) v = 0;
            end
            cell_mem[base + j] = clamp_cell(v);
          end
        end
        if (r.last && class_trained[r.label] < 24'hFFFFFF) class_trained[r.label]++;
      end
    end else if (r.mode <= MODE_RESP_SUM) begin
      for (int c = 0; c < n; c++) begin
        v = cell_mem[(c * 64 + int'(r.ram)) * 256 + r.addr];
        if (r.mode == MODE_RESP_COUNT) v = (v > bleach_level) ? 1 : 0;
        class_acc[c] = clamp_score(class_acc[c] + v);
      end
      if (r.last) begin
        best = 0;
        for (int c = 1; c < n; c++) if (class_acc[c] > class_acc[best]) best = c;
        for (int c = 0; c < n; c++) begin
          s = '{cls: c[1:0], score: class_acc[c][21:0], count: class_trained[c][23:0],
                best: best[1:0], err: 1'b0, lastr: (c + 1 == n)};
          outq.push_back(s);
        end
      end
    end
    if (r.last) for (int c = 0; c < 4; c++) class_acc[c] = 0;
  endfunction

  task automatic write_config(input logic [15:0] thr, input logic [14:0] inc,
                              input logic [14:0] dec, input logic [15:0] cnt);
    logic [15:0] vals [4];
    vals = '{thr, {1'b0, inc}, {1'b0, dec}, cnt};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[1:0];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    bleach_level = thr;
    inc_amount   = inc;
    dec_amount   = dec;
    classes_cfg  = cnt[2:0];
  endtask

  task automatic send_request(input request_t r, input bit typed, input score_t want);
    score_t got[$];
    int gap;
    if (!quiet && $urandom_range(5) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= r.mode;
    class_label_i <= r.label;
    ram_index_i   <= r.ram;
    ram_address_i <= r.addr;
    value_i       <= r.value;
    last_i        <= r.last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    classify_step(r, got);
    if (typed) pending_scores.push_back(want);
    else foreach (got[k]) pending_scores.push_back(got[k]);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  function automatic request_t rand_request(input logic [2:0] mode, input bit last);
    request_t r;
    r.mode  = mode;
    r.label = ($urandom_range(4) == 0) ? $urandom_range(3) : $urandom_range(active_classes() - 1);
    r.ram   = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3);
    r.addr  = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(7);
    case ($urandom_range(3))
      0: r.value = 16'sh7FFF;
      1: r.value = -16'sh8000;
      default: r.value = $urandom_range(16'hFFFF);
    endcase
    r.last  = last;
    return r;
  endfunction

  // Build one sample: a train or respond run, occasionally noise or a broken run.
  function automatic void build_sample();
    int len;
    logic [2:0] m;
    len = $urandom_range(1, 6);
    case ($urandom_range(9))
      0: begin
        for (int i = 0; i < len; i++)
          sample_q.push_back(rand_request($urandom_range(7), $urandom_range(1)));
        return;
      end
      1, 2, 3: m = ($urandom_range(9) == 0) ? MODE_TRAIN_FORGET
                  : ($urandom_range(1) ? MODE_TRAIN : MODE_TRAIN_VALUE);
      default: m = $urandom_range(1) ? MODE_RESP_COUNT : MODE_RESP_SUM;
    endcase
    for (int i = 0; i < len; i++) begin
      if (m >= MODE_RESP_COUNT && $urandom_range(5) == 0)
        sample_q.push_back(rand_request($urandom_range(MODE_RESP_COUNT, MODE_RESP_SUM),
                                        i == len - 1));
      else if (m >= MODE_RESP_COUNT && $urandom_range(15) == 0)
        sample_q.push_back(rand_request($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI),
                                        i == len - 1));
      else sample_q.push_back(rand_request(m, i == len - 1));
    end
  endfunction

  function automatic void add_row(input logic [2:0] mode, input logic [1:0] label,
                                  input logic [5:0] ram, input logic [7:0] addr,
                                  input logic signed [15:0] value, input logic last);
    row_t row;
    row.req   = '{mode, label, ram, addr, value, last};
    row.typed = 0;
    row.want  = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_label_error_row(input logic [1:0] label);
    row_t row;
    row.req   = '{MODE_TRAIN, label, 6'd9, 8'd9, 16'sd0, 1'b1};
    row.typed = 1;
    row.want  = '{cls: label, score: '0, count: '0, best: '0, err: 1'b1, lastr: 1'b1};
    dir_rows.push_back(row);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(7) == 0) begin
      stall_left  <= $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    score_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{class_index_o, score_o, train_count_o, best_class_o, error_o, last_result_o};
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_scores.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    row_t row;
    logic [15:0] thr [PhaseCount];
    logic [14:0] inc [PhaseCount];
    logic [14:0] dec [PhaseCount];
    logic [15:0] cnt [PhaseCount];
    int sent;
    foreach (cell_mem[i]) cell_mem[i] = '0;
    for (int c = 0; c < 4; c++) begin
      class_acc[c] = 0;
      class_trained[c] = 0;
    end
    bleach_level = '0;
    inc_amount   = 15'd1;
    dec_amount   = 15'd1;
    classes_cfg  = 3'd2;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(MODE_RESP_COUNT, 2'd0, 6'd0, 8'd0, 16'sd0, 1'b1);
    add_row(MODE_TRAIN, 2'd0, 6'd0, 8'd0, 16'sd0, 1'b1);
    add_row(MODE_TRAIN, 2'd1, 6'd63, 8'd255, -16'sd1, 1'b1);
    add_label_error_row(2'd2);
    add_label_error_row(2'd3);
    add_row(MODE_TRAIN_VALUE, 2'd0, 6'd1, 8'd5, 16'sh7FFF, 1'b0);
    add_row(MODE_TRAIN_VALUE, 2'd0, 6'd1, 8'd5, 16'sh7FFF, 1'b1);
    add_row(MODE_TRAIN_VALUE, 2'd1, 6'd1, 8'd5, -16'sh8000, 1'b0);
    add_row(MODE_TRAIN_VALUE, 2'd1, 6'd1, 8'd5, -16'sh8000, 1'b1);
    add_row(MODE_TRAIN_VALUE, 2'd1, 6'd1, 8'd6, 16'sd100, 1'b0);
    add_row(MODE_RESP_COUNT, 2'd3, 6'd0, 8'd0, 16'sd0, 1'b0);
    add_row(MODE_RESP_COUNT, 2'd0, 6'd1, 8'd5, 16'sd0, 1'b0);
    add_row(MODE_RESP_COUNT, 2'd0, 6'd63, 8'd255, 16'sd0, 1'b1);
    add_row(MODE_RESP_SUM, 2'd0, 6'd1, 8'd5, 16'sd0, 1'b1);
    add_row(MODE_TRAIN_FORGET, 2'd1, 6'd1, 8'd6, 16'sd0, 1'b1);
    add_row(MODE_TRAIN_FORGET, 2'd0, 6'd1, 8'd255, 16'sd0, 1'b0);
    add_row(MODE_RESP_SUM, 2'd0, 6'd1, 8'd5, 16'sd0, 1'b0);
    add_row(MODE_RESP_COUNT, 2'd0, 6'd1, 8'd6, 16'sd0, 1'b0);
    add_row(MODE_UNUSED_HI, 2'd0, 6'd1, 8'd6, 16'sd0, 1'b0);
    add_row(MODE_RESP_SUM, 2'd1, 6'd1, 8'd6, 16'sd0, 1'b1);
    add_row(MODE_UNUSED_LO, 2'd0, 6'd0, 8'd0, 16'sd0, 1'b1);
    add_row(MODE_RESP_SUM, 2'd0, 6'd0, 8'd0, 16'sd0, 1'b1);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_request(row.req, row.typed, row.want);
    end
    drain();

    thr = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'h8000, 16'h0000};
    inc = '{15'h7FFF, 15'h0000, 15'd1, 15'd3, 15'h7FFF, 15'd2, 15'd1, 15'd5};
    dec = '{15'h0000, 15'h7FFF, 15'd1, 15'd2, 15'd1, 15'h7FFF, 15'h0000, 15'd1};
    cnt = '{16'd4, 16'd1, 16'd0, 16'd7, 16'd3, 16'hFFFC, 16'd4, 16'd2};
    for (int p = 0; p < PhaseCount; p++) begin
      if (p >= 3 && p < PhaseCount - 2) thr[p] = $urandom_range(16'hFFFF);
      write_config(thr[p], inc[p], dec[p], cnt[p]);
      quiet = (p == PhaseCount - 1);
      sent = 0;
      while (sent < PhaseItems) begin
        build_sample();
        while (sample_q.size() != 0) begin
          send_request(sample_q.pop_front(), 0, '0);
          sent++;
        end
      end
      drain();
    end

    if (mismatches == 0 && pending_scores.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
